// ===== hw/rtl/isl_pkg.sv =====
// Package with the types and codes shared by the indexed sequential list block.
`default_nettype none

package isl_pkg;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One request transaction.
  typedef struct packed {
    op_t                opcode;
    logic [4:0]         position;
    logic signed [31:0] value_in;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    status_t            status;
    logic signed [31:0] value_out;
    logic [3:0]         found_index;
    logic [4:0]         entry_count;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } isl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } isl_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_sequential_list.sv =====
// An accepted transaction is captured, then executed, then reported through the output register.
// While results are taken promptly, the next request is accepted in the cycle that reports
// the previous one; the execute step (shift and compare in all cells) comes between the two.
// Reset empties the list and clears the output valid flag.
`default_nettype none

module indexed_sequential_list #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire isl_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output isl_pkg::out_item_t      out_data
);

  isl_pkg::isl_cmd_t  cmd;
  isl_pkg::isl_stat_t stat;

  // Sequencer.
  isl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // List storage and result formation.
  isl_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/isl_ctrl.sv =====
// Controller state machine that sequences capture, execution and reporting.
`default_nettype none

module isl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output isl_pkg::isl_cmd_t       cmd,
  input  wire isl_pkg::isl_stat_t stat
);

  isl_pkg::state_t state_r;
  isl_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands. A new transaction may enter in the cycle that
  // reports the previous one, once the output register can take that result.
  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.finish  = 1'b0;
    case (state_r)
      isl_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = isl_pkg::S_EXEC;
        end
      end
      isl_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = isl_pkg::S_FINISH;
      end
      isl_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = isl_pkg::S_EXEC;
          end else begin
            state_nxt = isl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = isl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/isl_datapath.sv =====
// Datapath: entry cells, count, request and result registers, output register.
`default_nettype none

module isl_datapath #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire isl_pkg::isl_cmd_t   cmd,
  output isl_pkg::isl_stat_t       stat,
  input  wire isl_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output isl_pkg::out_item_t       out_data
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > 5) ? CW : 5;

  isl_pkg::in_item_t       req_r;
  logic [DATA_WIDTH-1:0]   entries_r   [CAPACITY];
  logic [DATA_WIDTH-1:0]   entries_nxt [CAPACITY];
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [CAPACITY-1:0]     match_r;
  isl_pkg::status_t        res_status_r;
  isl_pkg::status_t        res_status_nxt;
  logic [DATA_WIDTH-1:0]   res_value_r;
  logic [DATA_WIDTH-1:0]   res_value_nxt;
  logic                    out_valid_r;
  isl_pkg::out_item_t      out_data_r;

  logic [CMPW-1:0]         pos_ext;
  logic [CMPW-1:0]         cnt_ext;
  logic [IW-1:0]           pos_idx;
  logic [DATA_WIDTH-1:0]   val_st;
  logic                    ins_ok;
  logic                    del_ok;
  logic [IW-1:0]           hit_idx;
  isl_pkg::out_item_t      result;

  assign pos_ext = CMPW'(req_r.position);
  assign cnt_ext = CMPW'(count_r);
  assign pos_idx = pos_ext[IW-1:0];
  assign val_st  = DATA_WIDTH'($unsigned(req_r.value_in));

  // Request register, loaded when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
  end

  // Decode the operation and its result against the current count.
  always_comb begin
    res_status_nxt = isl_pkg::ST_OK;
    res_value_nxt  = '0;
    count_nxt      = count_r;
    ins_ok         = 1'b0;
    del_ok         = 1'b0;
    case (req_r.opcode)
      isl_pkg::OP_GET: begin
        if (pos_ext >= cnt_ext) begin
          res_status_nxt = isl_pkg::ST_BAD_INDEX;
        end else begin
          res_value_nxt = entries_r[pos_idx];
        end
      end
      isl_pkg::OP_LOCATE: begin
        res_status_nxt = isl_pkg::ST_OK;
      end
      isl_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          res_status_nxt = isl_pkg::ST_BAD_INDEX;
        end else if (count_r == CW'(CAPACITY)) begin
          res_status_nxt = isl_pkg::ST_FULL;
        end else begin
          ins_ok    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      isl_pkg::OP_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          res_status_nxt = isl_pkg::ST_BAD_INDEX;
        end else begin
          del_ok        = 1'b1;
          res_value_nxt = entries_r[pos_idx];
          count_nxt     = count_r - 1'b1;
        end
      end
      default: begin
        res_status_nxt = isl_pkg::ST_BAD_INDEX;
      end
    endcase
  end

  // Each cell picks its own next value: hold, shift up, shift down, load or clear.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_nxt[i] = entries_r[i];
      if (ins_ok) begin
        if (CMPW'(i) == pos_ext) begin
          entries_nxt[i] = val_st;
        end else if (CMPW'(i) > pos_ext && CMPW'(i) <= cnt_ext) begin
          entries_nxt[i] = entries_r[(i == 0) ? 0 : i - 1];
        end
      end else if (del_ok) begin
        if (CMPW'(i) >= pos_ext) begin
          if (CMPW'(i + 1) < cnt_ext) begin
            entries_nxt[i] = entries_r[(i == CAPACITY - 1) ? i : i + 1];
          end else if (CMPW'(i + 1) == cnt_ext) begin
            entries_nxt[i] = '0;
          end
        end
      end
    end
  end

  // Execution step: update the cells and count, compare all cells in parallel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries_r[i] <= entries_nxt[i];
        match_r[i]   <= (CMPW'(i) < cnt_ext) && (entries_r[i] == val_st);
      end
      res_status_r <= res_status_nxt;
      res_value_r  <= res_value_nxt;
    end
  end

  // Lowest matching cell.
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  // Assemble the result transaction.
  always_comb begin
    result.status      = res_status_r;
    result.value_out   = 32'(res_value_r);
    result.found_index = '0;
    result.entry_count = 5'(count_r);
    if (req_r.opcode == isl_pkg::OP_LOCATE) begin
      if (|match_r) begin
        result.status      = isl_pkg::ST_OK;
        result.found_index = 4'(hit_idx);
      end else begin
        result.status = isl_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Output register decouples the result from the downstream stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= result;
    end
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // The count never exceeds the capacity.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A result is only loaded when the output register can take it.
  a_finish_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  // One operation changes the count by at most one.
  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
         count_r == $past(count_r) - 1'b1))
    else $error("entry count moved by more than one");

  // The count only changes in the execution step.
  a_count_exec : assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(count_r))
    else $error("entry count changed outside execution");

endmodule

`default_nettype wire

// ===== tb/sv/tb_indexed_sequential_list.sv =====
// Self-checking testbench for the indexed sequential list: directed and random requests.
`timescale 1ns / 100ps

module tb_indexed_sequential_list;

  localparam int LIST_CAP   = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 8;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTY
  } stall_mode_t;

  // Clock, reset and the two channels.
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  isl_pkg::in_item_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  isl_pkg::out_item_t out_data;

  // Mirror of the list contents used to predict each result.
  logic [31:0]        list_mem [LIST_CAP];
  int                 list_len;
  int                 list_peak;
  isl_pkg::out_item_t pending_results [$];

  // Traffic shaping.
  logic        sender_gaps = 1'b0;
  int          burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_run   = 0;
  logic        filling     = 1'b1;
  logic [31:0] value_pool [8];

  // Bookkeeping.
  int n_errors  = 0;
  int idle_cnt  = 0;
  int op_seen     [4];
  int status_seen [4];

  indexed_sequential_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Apply one request to the mirrored list and return the result it should produce.
  function automatic isl_pkg::out_item_t list_apply(input isl_pkg::in_item_t req);
    isl_pkg::out_item_t res;
    int                 pos;
    int                 i;
    logic               hit;
    logic [31:0]        val;
    res = '0;
    pos = int'(req.position);
    val = req.value_in;
    hit = 1'b0;
    case (req.opcode)
      isl_pkg::OP_GET: begin
        if (pos >= list_len) res.status = isl_pkg::ST_BAD_INDEX;
        else res.value_out = list_mem[pos];
      end
      isl_pkg::OP_LOCATE: begin
        for (i = 0; i < list_len; i++) begin
          if (!hit && list_mem[i] == val) begin
            hit = 1'b1;
            res.found_index = i[3:0];
          end
        end
        if (!hit) res.status = isl_pkg::ST_NOT_FOUND;
      end
      isl_pkg::OP_INSERT: begin
        // A position past the tail is rejected before the full check.
        if (pos > list_len) begin
          res.status = isl_pkg::ST_BAD_INDEX;
        end else if (list_len >= LIST_CAP) begin
          res.status = isl_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      default: begin
        if (pos >= list_len) begin
          res.status = isl_pkg::ST_BAD_INDEX;
        end else begin
          res.value_out = list_mem[pos];
          list_len--;
          for (i = pos; i < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_mem[list_len] = '0;
        end
      end
    endcase
    res.entry_count = list_len[4:0];
    if (list_len > list_peak) list_peak = list_len;
    return res;
  endfunction

  // Present one request, wait until it is taken, then record its expected result.
  task automatic send_req(input isl_pkg::op_t op, input int unsigned pos,
                          input logic [31:0] val);
    isl_pkg::in_item_t req;
    int                gap;
    req.opcode   = op;
    req.position = pos[4:0];
    req.value_in = val;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(list_apply(req));
    op_seen[op]++;
    // Bursts of random length separated by random gaps.
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Position: mostly inside the legal range, sometimes anywhere in the field; always anywhere for searches.
  function automatic int unsigned pick_position(input isl_pkg::op_t op);
    if (op == isl_pkg::OP_LOCATE || $urandom_range(0, 99) < 12) return $urandom_range(0, 31);
    if (op == isl_pkg::OP_INSERT) return $urandom_range(0, list_len);
    if (list_len == 0) return 0;
    return $urandom_range(0, list_len - 1);
  endfunction

  // Value: a stored entry for most searches, else a pool, random or one-hot value.
  function automatic logic [31:0] pick_value(input isl_pkg::op_t op);
    int roll;
    roll = $urandom_range(0, 99);
    if (op == isl_pkg::OP_LOCATE && list_len > 0 && roll < 65)
      return list_mem[$urandom_range(0, list_len - 1)];
    if (roll < 45) return value_pool[$urandom_range(0, 7)];
    if (roll < 80) return $urandom;
    return 32'd1 << $urandom_range(0, 31);
  endfunction

  // Receiver stall pattern.
  always @(posedge clk) begin
    case (stall_mode)
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
      STALL_BURSTY: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, 12);
          out_stall <= ~out_stall;
        end else begin
          stall_run--;
        end
      end
      default: out_stall <= 1'b0;
    endcase
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    isl_pkg::out_item_t want_res;
    if (rst_n && out_valid && !out_stall) begin
      status_seen[out_data.status]++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected result st=%0d val=%h idx=%0d cnt=%0d",
                   out_data.status, out_data.value_out, out_data.found_index,
                   out_data.entry_count);
      end else begin
        want_res = pending_results.pop_front();
        if (out_data.status !== want_res.status ||
            out_data.value_out !== want_res.value_out ||
            out_data.found_index !== want_res.found_index ||
            out_data.entry_count !== want_res.entry_count) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"ERROR: expected st=%0d val=%h idx=%0d cnt=%0d, ",
                      "got st=%0d val=%h idx=%0d cnt=%0d"},
                     want_res.status, want_res.value_out, want_res.found_index,
                     want_res.entry_count, out_data.status, out_data.value_out,
                     out_data.found_index, out_data.entry_count);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cnt, pending_results.size());
        $display("tb_indexed_sequential_list: done, errors");
        $finish;
      end
    end
  end

  // Reads, searches and deletes on an empty list, and positions past the tail.
  task automatic test_empty_list();
    send_req(isl_pkg::OP_GET, 0, 32'h0);
    send_req(isl_pkg::OP_DELETE, 0, 32'h0);
    send_req(isl_pkg::OP_LOCATE, 0, 32'h0);
    send_req(isl_pkg::OP_INSERT, 1, 32'h1234_5678);
    send_req(isl_pkg::OP_INSERT, 31, 32'hFFFF_FFFF);
    send_req(isl_pkg::OP_GET, 31, 32'h0);
  endtask

  // Head, middle and tail inserts, a full list, duplicates and edge deletes.
  task automatic test_capacity_limits();
    int i;
    send_req(isl_pkg::OP_INSERT, 0, 32'h7FFF_FFFF);
    send_req(isl_pkg::OP_INSERT, 0, 32'h8000_0000);
    send_req(isl_pkg::OP_INSERT, 3, 32'h0000_0001);
    send_req(isl_pkg::OP_INSERT, 1, 32'hFFFF_FFFF);
    send_req(isl_pkg::OP_INSERT, 3, 32'h0000_0000);
    // Fill to capacity with tail inserts, repeating one earlier value.
    for (i = 0; i < LIST_CAP - 4; i++)
      send_req(isl_pkg::OP_INSERT, list_len, (i == 6) ? 32'hFFFF_FFFF : 32'h5A5A_0000 + i);
    send_req(isl_pkg::OP_INSERT, LIST_CAP, 32'h0BAD_0BAD);
    send_req(isl_pkg::OP_INSERT, LIST_CAP + 1, 32'h0BAD_0BAD);
    send_req(isl_pkg::OP_INSERT, 0, 32'h0BAD_0BAD);
    send_req(isl_pkg::OP_LOCATE, 0, 32'hFFFF_FFFF);
    send_req(isl_pkg::OP_GET, LIST_CAP - 1, 32'h0);
    send_req(isl_pkg::OP_DELETE, LIST_CAP - 1, 32'h0);
    send_req(isl_pkg::OP_DELETE, 0, 32'h0);
  endtask

  // Random requests that drift between filling and draining the list.
  task automatic run_random_segment(input int n_items);
    int           k;
    int           roll;
    isl_pkg::op_t op;
    int unsigned  pos;
    logic [31:0]  val;
    for (k = 0; k < n_items; k++) begin
      if (filling && list_len >= LIST_CAP) filling = 1'b0;
      else if (!filling && list_len == 0) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = ~filling;
      roll = $urandom_range(0, 99);
      if (roll < 20) op = isl_pkg::OP_GET;
      else if (roll < 40) op = isl_pkg::OP_LOCATE;
      else if (roll < 70) op = filling ? isl_pkg::OP_INSERT : isl_pkg::OP_DELETE;
      else if (roll < 85) op = filling ? isl_pkg::OP_DELETE : isl_pkg::OP_INSERT;
      else op = isl_pkg::op_t'($urandom_range(0, 3));
      pos = pick_position(op);
      val = pick_value(op);
      send_req(op, pos, val);
    end
  endtask

  // Back-to-back traffic with the receiver always ready.
  task automatic test_random_full_rate();
    sender_gaps = 1'b0;
    stall_mode  = STALL_NONE;
    run_random_segment(200);
  endtask

  // Random traffic under sender gaps and receiver stalls.
  task automatic test_random_flow_control();
    sender_gaps = 1'b1;
    stall_mode  = STALL_RANDOM;
    run_random_segment(220);
    sender_gaps = 1'b0;
    stall_mode  = STALL_BURSTY;
    run_random_segment(210);
    sender_gaps = 1'b1;
    run_random_segment(220);
  endtask

  // Test sequence.
  initial begin
    int i;
    for (i = 0; i < LIST_CAP; i++) list_mem[i] = '0;
    for (i = 0; i < 4; i++) begin
      op_seen[i]     = 0;
      status_seen[i] = 0;
    end
    list_len      = 0;
    list_peak     = 0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h7FFF_FFFF;
    value_pool[3] = 32'h8000_0000;
    for (i = 4; i < 8; i++) value_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_capacity_limits();
    test_random_full_rate();
    test_random_flow_control();
    in_valid <= 1'b0;

    // Let outstanding results drain, then allow for the pipeline latency.
    while (pending_results.size() != 0) @(posedge clk);
    stall_mode = STALL_NONE;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      n_errors++;
      $display("ERROR: %0d expected results never arrived", pending_results.size());
    end

    $display("Sent get %0d, locate %0d, insert %0d, delete %0d; list peaked at %0d entries.",
             op_seen[isl_pkg::OP_GET], op_seen[isl_pkg::OP_LOCATE],
             op_seen[isl_pkg::OP_INSERT], op_seen[isl_pkg::OP_DELETE], list_peak);
    $display("Results: ok %0d, bad index %0d, full %0d, not found %0d; %0d errors.",
             status_seen[isl_pkg::ST_OK], status_seen[isl_pkg::ST_BAD_INDEX],
             status_seen[isl_pkg::ST_FULL], status_seen[isl_pkg::ST_NOT_FOUND], n_errors);
    if (n_errors == 0) begin
      $display("tb_indexed_sequential_list: done, clean");
    end else begin
      $display("tb_indexed_sequential_list: done, errors");
    end
    $finish;
  end

endmodule
